/* rtl/core/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

  // field widths fixed by the interface
  localparam int BS_W   = 13;   // block_bytes
  localparam int BIU_W  = 11;   // blocks_in_use
  localparam int ADDR_W = 32;
  localparam int CFG_W  = 32;
  localparam int CFG_IW = 2;

  // block marks
  localparam logic [1:0] MARK_UNUSED = 2'b01;
  localparam logic [1:0] MARK_TAIL   = 2'b10;
  localparam logic [1:0] MARK_HEAD   = 2'b11;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_UNALIGNED = 2'd2;
  localparam logic [1:0] ST_NOT_HEAD  = 2'd3;

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BLOCKS_IN_USE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BODY_BASE     = 2'd2;

  // divider handshake
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [BS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quotient;
    logic [BS_W-1:0]   remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/ffba_ram.sv */
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/ffba_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ffba_div
  import ffba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(ADDR_W);

  logic              run_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [ADDR_W-1:0] dvd_r;
  logic [BS_W-1:0]   rem_r;
  logic [BS_W-1:0]   dsr_r;
  logic [BS_W:0]     trial;
  logic              fits;
  logic [BS_W:0]     diff;

  always_comb begin
    trial = {rem_r, dvd_r[ADDR_W-1]};
    fits  = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        dvd_r <= req.dividend;
        dsr_r <= req.divisor;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= fits ? diff[BS_W-1:0] : trial[BS_W-1:0];
        dvd_r <= {dvd_r[ADDR_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ADDR_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

/* rtl/core/first_fit_block_allocator_top.sv */
// Channel    | Ports                                            | Handshake
// config     | cfg_we, cfg_index, cfg_data                      | write when cfg_we high
// request    | in_req_type, in_request_bytes, in_free_address   | start && !busy
// result     | out_block_address, out_status                    | out_valid, one cycle
//
// Allocate: a divide, then a mark scan of up to the first count blocks (count is
// blocks_in_use capped at NUM_BLOCKS, one read a cycle), one write per block taken.
// Free: a divide, then a tail walk from the freed head block up to index count.
// Either then passes through S_DONE before the out_valid strobe; busy drops with it.
// After reset a clearing pass over all NUM_BLOCKS entries sets every mark unused.
// Results cannot be stalled: out_valid is a single-cycle strobe.
`default_nettype none

module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_req_type,
  input  wire logic [ADDR_W-1:0] in_request_bytes,
  input  wire logic [ADDR_W-1:0] in_free_address,
  output logic                   out_valid,
  output logic      [ADDR_W-1:0] out_block_address,
  output logic      [1:0]        out_status
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int PW = IW + BS_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_MARK, S_WALK, S_DONE
  } state_t;

  state_t state_r;

  logic [BS_W-1:0]   block_bytes_r;
  logic [BIU_W-1:0]  blocks_in_use_r;
  logic [ADDR_W-1:0] body_base_r;

  logic              req_type_r;
  logic [CW-1:0]     iss_r;
  logic              pend_r;
  logic [IW-1:0]     pend_idx_r;
  logic [CW-1:0]     run_r;
  logic [CW-1:0]     need_r;
  logic [IW-1:0]     start_idx_r;
  logic [IW-1:0]     wr_idx_r;
  logic [CW-1:0]     mark_left_r;
  logic              first_r;
  logic              alloc_ok_r;
  logic [1:0]        st_r;
  logic [PW-1:0]     prod_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_block_address_r;
  logic [1:0]        out_status_r;

  logic [BS_W-1:0]   bs_eff;
  logic [CW-1:0]     count;
  logic              accept;
  logic              issue;
  logic [CW-1:0]     run_inc;
  logic [ADDR_W:0]   need_full;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [1:0]    mem_rdata;

  always_comb begin
    bs_eff  = (block_bytes_r == '0) ? BS_W'(1) : block_bytes_r;
    count   = (32'(blocks_in_use_r) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                      : CW'(blocks_in_use_r);
    accept  = start && (state_r == S_IDLE);
    issue   = iss_r < count;
    run_inc = run_r + CW'(1);
    need_full = {1'b0, div_rsp.quotient} + (ADDR_W + 1)'(div_rsp.remainder != '0);
    if (need_full == '0) begin
      need_full = (ADDR_W + 1)'(1);
    end
  end

  always_comb begin
    div_req.start    = accept;
    div_req.divisor  = bs_eff;
    div_req.dividend = (in_req_type == REQ_FREE) ? in_free_address - body_base_r
                                                 : in_request_bytes;
  end

  ffba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // write port: clearing pass, run marking, and head and tail release on free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx_r;
    mem_wdata = MARK_UNUSED;
    unique case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = first_r ? MARK_HEAD : MARK_TAIL;
      end
      S_WALK: begin
        mem_waddr = pend_idx_r;
        mem_we    = pend_r && ((first_r && mem_rdata == MARK_HEAD) ||
                               (!first_r && mem_rdata == MARK_TAIL));
      end
      default: mem_we = 1'b0;
    endcase
  end

  ffba_ram #(
    .WIDTH (2),
    .DEPTH (NUM_BLOCKS)
  ) u_marks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (iss_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r   <= BS_W'(16);
      blocks_in_use_r <= BIU_W'(1024);
      body_base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES:   block_bytes_r   <= cfg_data[BS_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_data[BIU_W-1:0];
        CFG_BODY_BASE:     body_base_r     <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wr_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          wr_idx_r <= wr_idx_r + IW'(1);
          if (wr_idx_r == IW'(NUM_BLOCKS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_type_r <= in_req_type;
            alloc_ok_r <= 1'b0;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            pend_r  <= 1'b0;
            run_r   <= '0;
            first_r <= 1'b1;
            if (req_type_r == REQ_ALLOC) begin
              if (need_full > (ADDR_W + 1)'(count)) begin
                st_r    <= ST_NO_SPACE;
                state_r <= S_DONE;
              end else begin
                need_r  <= CW'(need_full);
                iss_r   <= '0;
                state_r <= S_SCAN;
              end
            end else if (div_rsp.remainder != '0) begin
              st_r    <= ST_UNALIGNED;
              state_r <= S_DONE;
            end else if (div_rsp.quotient >= 32'(count)) begin
              st_r    <= ST_NOT_HEAD;
              state_r <= S_DONE;
            end else begin
              iss_r   <= CW'(div_rsp.quotient);
              state_r <= S_WALK;
            end
          end
        end
        S_SCAN: begin
          // read one block ahead of the one being judged
          pend_r     <= issue;
          pend_idx_r <= iss_r[IW-1:0];
          if (issue) begin
            iss_r <= iss_r + CW'(1);
          end
          if (pend_r) begin
            if (mem_rdata == MARK_UNUSED) begin
              run_r <= run_inc;
              if (run_r == '0) begin
                start_idx_r <= pend_idx_r;
              end
              if (run_inc == need_r) begin
                wr_idx_r    <= (run_r == '0) ? pend_idx_r : start_idx_r;
                start_idx_r <= (run_r == '0) ? pend_idx_r : start_idx_r;
                mark_left_r <= need_r;
                first_r     <= 1'b1;
                state_r     <= S_MARK;
              end
            end else begin
              run_r <= '0;
            end
          end else if (!issue) begin
            st_r    <= ST_NO_SPACE;
            state_r <= S_DONE;
          end
        end
        S_MARK: begin
          prod_r      <= PW'(start_idx_r) * PW'(bs_eff);
          wr_idx_r    <= wr_idx_r + IW'(1);
          mark_left_r <= mark_left_r - CW'(1);
          first_r     <= 1'b0;
          if (mark_left_r == CW'(1)) begin
            alloc_ok_r <= 1'b1;
            st_r       <= ST_OK;
            state_r    <= S_DONE;
          end
        end
        S_WALK: begin
          pend_r     <= issue;
          pend_idx_r <= iss_r[IW-1:0];
          if (issue) begin
            iss_r <= iss_r + CW'(1);
          end
          if (pend_r) begin
            first_r <= 1'b0;
            if (first_r && mem_rdata != MARK_HEAD) begin
              st_r    <= ST_NOT_HEAD;
              state_r <= S_DONE;
            end else if (!first_r && mem_rdata != MARK_TAIL) begin
              st_r    <= ST_OK;
              state_r <= S_DONE;
            end
          end else if (!issue) begin
            st_r    <= ST_OK;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r         <= 1'b1;
          out_status_r        <= st_r;
          out_block_address_r <= alloc_ok_r ? body_base_r + 32'(prod_r) : '0;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_block_address = out_block_address_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

/* rtl/core/ffba_chk.sv */
`default_nettype none

module ffba_chk
  import ffba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [ADDR_W-1:0] out_block_address,
  input wire logic [1:0]        out_status
);

  // reset starts the clearing pass, which holds off requests
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("block not busy after reset");

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result for a transaction");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_address == '0)
    else $error("failed transaction returned an address");

endmodule

bind first_fit_block_allocator_top ffba_chk u_ffba_chk (.*);

`default_nettype wire
